// ===== hw/rtl/hrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hrs_pkg;

  localparam int RING_DEPTH   = 32;
  localparam int RECORD_WIDTH = 64;
  localparam int PTR_W        = $clog2(RING_DEPTH);
  localparam int REQ_W        = 2;
  localparam int PORT_REC_W   = 64;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic [RECORD_WIDTH-1:0] rec_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE     = 2'd0,
    REQ_READ_NEXT = 2'd1,
    REQ_READ_LAST = 2'd2,
    REQ_ERASE     = 2'd3
  } req_t;

  // work for the back end
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_ZERO  = 2'd2,
    OP_EMPTY = 2'd3
  } op_t;

  typedef struct packed {
    op_t  op;
    ptr_t addr;
    rec_t data;
  } cmd_t;

  localparam ptr_t PTR_LAST = ptr_t'(RING_DEPTH - 1);

  function automatic ptr_t ring_next(input ptr_t p);
    ptr_t r;
    if (p == PTR_LAST) r = '0;
    else               r = p + ptr_t'(1);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/history_ring_store_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                Payload
// request   in         start, busy              in_req_type, in_record_in
// result    out        out_valid (one cycle)    out_status, out_record_out
//
// One request is taken per cycle while busy is low; its result passes through
// the command queue and then the registered read port of the record store.
// Reset is synchronous, active low; it clears the pointers and the queue,
// not the record store, so no clearing pass is needed.
// The result side cannot stall: busy rises only if the command queue fills,
// which does not happen while the back end drains one command per cycle.
module history_ring_store_top
  import hrs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [REQ_W-1:0]      in_req_type,
  input  wire logic [PORT_REC_W-1:0] in_record_in,
  output logic                       out_valid,
  output logic                       out_status,
  output logic [PORT_REC_W-1:0]      out_record_out
);

  logic accept;
  logic q_full;
  logic fr_push;
  cmd_t fr_cmd;
  logic bk_valid;
  cmd_t bk_cmd;

  // take a request only when the queue has room
  assign busy   = q_full;
  assign accept = start && !q_full;

  // front: pointer bookkeeping and classification of each request
  hrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req_type  (in_req_type),
    .record_in (in_record_in),
    .push      (fr_push),
    .cmd       (fr_cmd)
  );

  // hold classified commands between front and back
  hrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_push),
    .push_cmd  (fr_cmd),
    .full      (q_full),
    .pop_valid (bk_valid),
    .pop_cmd   (bk_cmd)
  );

  // back: record store access and result formatting
  hrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (bk_valid),
    .cmd        (bk_cmd),
    .res_valid  (out_valid),
    .res_status (out_status),
    .res_record (out_record_out)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/hrs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hrs_front
  import hrs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [REQ_W-1:0]      req_type,
  input  wire logic [PORT_REC_W-1:0] record_in,
  output logic                       push,
  output cmd_t                       cmd
);

  ptr_t head_r, head_nxt;
  ptr_t tail_r, tail_nxt;
  ptr_t cursor_r, cursor_nxt;
  ptr_t last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      cursor_r <= '0;
      last_r   <= '0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      cursor_r <= cursor_nxt;
      last_r   <= last_nxt;
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cursor_nxt = cursor_r;
    last_nxt   = last_r;
    push       = accept;
    cmd.op     = OP_ZERO;
    cmd.addr   = head_r;
    cmd.data   = record_in[RECORD_WIDTH-1:0];
    if (accept) begin
      unique case (req_t'(req_type))
        REQ_WRITE: begin
          // full ring: drop the oldest entry
          if (tail_r == ring_next(head_r)) begin
            tail_nxt   = ring_next(tail_r);
            cursor_nxt = ring_next(tail_r);
          end
          last_nxt = head_r;
          head_nxt = ring_next(head_r);
          cmd.op   = OP_WRITE;
          cmd.addr = head_r;
        end
        REQ_ERASE: begin
          head_nxt   = '0;
          tail_nxt   = '0;
          cursor_nxt = '0;
          last_nxt   = '0;
          cmd.op     = OP_ZERO;
        end
        REQ_READ_NEXT, REQ_READ_LAST: begin
          if (cursor_r == head_r) begin
            cursor_nxt = tail_r;
            cmd.op     = OP_EMPTY;
          end else if (req_t'(req_type) == REQ_READ_LAST) begin
            cmd.op   = OP_READ;
            cmd.addr = last_r;
          end else begin
            cmd.op     = OP_READ;
            cmd.addr   = cursor_r;
            cursor_nxt = ring_next(cursor_r);
          end
        end
        default: cmd.op = OP_ZERO;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hrs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hrs_queue
  import hrs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      pop_valid,
  output cmd_t      pop_cmd
);

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  // the back end takes an entry every cycle that one is waiting
  assign do_pop    = pop_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + Q_CNT_W'(1);
    else if (!do_push && do_pop) count_nxt = count_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hrs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hrs_back
  import hrs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cmd_valid,
  input  wire cmd_t                   cmd,
  output logic                        res_valid,
  output logic                        res_status,
  output logic [PORT_REC_W-1:0]       res_record
);

  rec_t store [RING_DEPTH];
  rec_t rd_data_r;
  op_t  op_r;
  logic valid_r;

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      if (cmd.op == OP_WRITE) store[cmd.addr] <= cmd.data;
      rd_data_r <= store[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      op_r    <= OP_ZERO;
    end else begin
      valid_r <= cmd_valid;
      if (cmd_valid) op_r <= cmd.op;
    end
  end

  always_comb begin
    res_valid  = valid_r;
    res_status = (op_r == OP_EMPTY);
    res_record = '0;
    if (op_r == OP_READ) res_record[RECORD_WIDTH-1:0] = rd_data_r;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hrs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hrs_checker
  import hrs_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic [REQ_W-1:0]      in_req_type,
  input wire logic                  out_valid,
  input wire logic                  out_status,
  input wire logic [PORT_REC_W-1:0] out_record_out
);

  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result missing two cycles after request");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without request");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy && in_req_type == REQ_WRITE, 2))
      |-> (!out_status && out_record_out == '0))
    else $error("write result not zero");

endmodule

bind history_ring_store_top hrs_checker u_hrs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_record_out (out_record_out)
);
`default_nettype wire
